FILE: sv/ccad_pkg.sv
// package: widths, codes and control structs for the crank cadence block
package ccad_pkg;

  localparam int unsigned FLAGS_W = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned NUM_W   = 2 * WORD_W;
  localparam int unsigned CNT_W   = $clog2(NUM_W);
  localparam int unsigned MISS_W  = 2;

  localparam logic [FLAGS_W-1:0] FLAGS_MATCH = 8'h23;
  localparam logic [MISS_W-1:0]  MISS_LIMIT  = 2'd3;
  localparam logic [WORD_W-1:0]  CADENCE_MAX = 16'hffff;

  // 61440 = 60 * 1024 = 2^16 - 2^12
  localparam int unsigned SCALE_HI_SH = 16;
  localparam int unsigned SCALE_LO_SH = 12;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [WORD_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: sv/ccad_in_if.sv
// interface: input item channel
interface ccad_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  flags;
  logic signed [15:0] power_watts;
  logic [15:0] crank_revs;
  logic [15:0] crank_time;

  modport source (output valid, flags, power_watts, crank_revs, crank_time, input ready);
  modport sink (input valid, flags, power_watts, crank_revs, crank_time, output ready);
endinterface

FILE: sv/ccad_out_if.sv
// interface: result item channel
interface ccad_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] power_out;
  logic [15:0] cadence_rpm;
  logic        cadence_updated;

  modport source (output valid, power_out, cadence_rpm, cadence_updated, input ready);
  modport sink (input valid, power_out, cadence_rpm, cadence_updated, output ready);
endinterface

FILE: sv/ccad_div.sv
// radix-2 restoring divider, one quotient bit a cycle, saturating 16-bit quotient
module ccad_div (
  input  logic              clk,
  input  logic              rst,
  input  ccad_pkg::div_req_t req,
  output ccad_pkg::div_rsp_t rsp
);

  logic [ccad_pkg::NUM_W-1:0]  acc;
  logic [ccad_pkg::WORD_W-1:0] rem;
  logic [ccad_pkg::WORD_W-1:0] den;
  logic [ccad_pkg::CNT_W-1:0]  count;
  logic                        busy;
  logic                        done;

  logic [ccad_pkg::WORD_W:0] rem_sh;
  logic [ccad_pkg::WORD_W:0] rem_sub;
  logic                      ge;

  assign rem_sh  = {rem, acc[ccad_pkg::NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= req.num;
      den   <= req.den;
      rem   <= '0;
      count <= ccad_pkg::CNT_W'(ccad_pkg::NUM_W - 1);
    end else if (busy) begin
      rem   <= ge ? rem_sub[ccad_pkg::WORD_W-1:0] : rem_sh[ccad_pkg::WORD_W-1:0];
      acc   <= {acc[ccad_pkg::NUM_W-2:0], ge};
      count <= count - 1'b1;
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quo  = (|acc[ccad_pkg::NUM_W-1:ccad_pkg::WORD_W]) ? ccad_pkg::CADENCE_MAX
                                                                : acc[ccad_pkg::WORD_W-1:0];

endmodule

FILE: sv/crank_cadence_from_power_packet.sv
// top level: crank cadence from a decoded cycling power measurement
//
//   channel  dir  handshake     payload
//   in       in   valid/ready   flags, power_watts, crank_revs, crank_time
//   out      out  valid/ready   power_out, cadence_rpm, cadence_updated
//
// an item with crank data and a usable change runs through the 32 single-bit steps of the
// divider; any other item goes from preparation straight to the done state
// one item at a time; the output register holds a result while the next item runs
// a full output register with the next result ready stalls the sequencer
// rst is synchronous and clears the stored pair, miss count and cadence
module crank_cadence_from_power_packet (
  input  logic clk,
  input  logic rst,
  ccad_in_if.sink    in,
  ccad_out_if.source out
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [ccad_pkg::WORD_W-1:0] power;
  logic                               match;
  logic [ccad_pkg::WORD_W-1:0]        revs;
  logic [ccad_pkg::WORD_W-1:0]        tnow;

  logic [ccad_pkg::WORD_W-1:0] prev_revs;
  logic [ccad_pkg::WORD_W-1:0] prev_time;
  logic [ccad_pkg::MISS_W-1:0] miss_count;
  logic [ccad_pkg::WORD_W-1:0] cadence_reg;
  logic                        updated;

  logic                               out_valid;
  logic signed [ccad_pkg::WORD_W-1:0] out_power;
  logic [ccad_pkg::WORD_W-1:0]        out_cadence;
  logic                               out_updated;

  logic [ccad_pkg::WORD_W-1:0] dtime;
  logic [ccad_pkg::WORD_W-1:0] drev;
  logic                        hit;
  logic                        accept;
  logic                        out_free;

  ccad_pkg::div_req_t div_req;
  ccad_pkg::div_rsp_t div_rsp;

  assign accept   = in.valid && in.ready;
  assign out_free = !out_valid || out.ready;
  assign in.ready = (state == ST_IDLE);

  assign dtime = (tnow >= prev_time) ? (tnow - prev_time) : (prev_time - tnow);
  assign drev  = revs - prev_revs;
  assign hit   = (revs > prev_revs) && (dtime != '0);

  assign div_req.start = (state == ST_PREP) && match && hit;
  assign div_req.num   = ({drev, ccad_pkg::SCALE_HI_SH'(0)})
                       - ccad_pkg::NUM_W'({drev, ccad_pkg::SCALE_LO_SH'(0)});
  assign div_req.den   = dtime;

  ccad_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_PREP;
      ST_PREP: state_next = div_req.start ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_rsp.done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev_revs   <= '0;
      prev_time   <= '0;
      miss_count  <= '0;
      cadence_reg <= '0;
      updated     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        updated <= 1'b0;
      end
      if (state == ST_PREP && match) begin
        prev_revs <= revs;
        prev_time <= tnow;
        if (!hit) begin
          if (miss_count >= ccad_pkg::MISS_LIMIT) begin
            cadence_reg <= '0;
          end else begin
            miss_count <= miss_count + 1'b1;
          end
        end
      end
      if (state == ST_DIV && div_rsp.done) begin
        cadence_reg <= div_rsp.quo;
        miss_count  <= '0;
        updated     <= 1'b1;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      power <= in.power_watts;
      match <= (in.flags == ccad_pkg::FLAGS_MATCH);
      revs  <= in.crank_revs;
      tnow  <= in.crank_time;
    end
    if (state == ST_DONE && out_free) begin
      out_power   <= power;
      out_cadence <= cadence_reg;
      out_updated <= updated;
    end
  end

  assign out.valid           = out_valid;
  assign out.power_out       = out_power;
  assign out.cadence_rpm     = out_cadence;
  assign out.cadence_updated = out_updated;

  a_div_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> state == ST_DIV)
    else $error("divider running outside the divide state");

  a_accept_to_prep: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_PREP)
    else $error("accepted item did not enter preparation");

  a_result_loads_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> out_valid && state == ST_IDLE)
    else $error("finished item not moved to the output register");

  a_update_clears_miss: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_rsp.done) |=> miss_count == '0 && updated)
    else $error("computed cadence did not clear the miss count");

endmodule

FILE: sim/tb_crank_cadence_from_power_packet.sv
// testbench: crank cadence block driven with directed and random readings, checked per item
module tb_crank_cadence_from_power_packet;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TICKS_PER_MIN = 60 * 1024;
  localparam int unsigned ITEMS         = 500;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [7:0]         flags;
    logic signed [15:0] power;
    logic [15:0]        revs;
    logic [15:0]        evt;
  } reading_t;

  typedef struct packed {
    logic signed [15:0] power;
    logic [15:0]        cadence;
    logic               updated;
  } cadence_t;

  typedef struct {
    reading_t    rd;
    bit          fixed;
    logic [15:0] cadence;
    bit          updated;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ccad_in_if  in_if ();
  ccad_out_if out_if ();

  crank_cadence_from_power_packet dut (
    .clk (clk),
    .rst (rst),
    .in  (in_if),
    .out (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [15:0] last_revs    = '0;
  logic [15:0] last_evt     = '0;
  logic [1:0]  misses       = '0;
  logic [15:0] held_cadence = '0;

  cadence_t    pending_cadence [$];
  row_t        plan [$];
  bit          row_fixed   = 1'b0;
  logic [15:0] row_cadence = '0;
  bit          row_updated = 1'b0;
  bit          hold_req    = 1'b0;
  int unsigned errors      = 0;
  int unsigned cycles      = 0;

  function automatic cadence_t predict_cadence(reading_t r);
    cadence_t    c;
    logic [15:0] dt;
    logic [47:0] q;
    c.power   = r.power;
    c.updated = 1'b0;
    if (r.flags == ccad_pkg::FLAGS_MATCH) begin
      dt = (r.evt >= last_evt) ? r.evt - last_evt : last_evt - r.evt;
      if (r.revs > last_revs && dt != 16'd0) begin
        q = (48'(r.revs - last_revs) * 48'(TICKS_PER_MIN)) / 48'(dt);
        held_cadence = (q > 48'(ccad_pkg::CADENCE_MAX)) ? ccad_pkg::CADENCE_MAX : q[15:0];
        misses    = '0;
        c.updated = 1'b1;
      end else begin
        if (misses == ccad_pkg::MISS_LIMIT) held_cadence = '0;
        else misses = misses + 2'd1;
      end
      last_revs = r.revs;
      last_evt  = r.evt;
    end
    c.cadence = held_cadence;
    return c;
  endfunction

  task automatic report_error(string what, cadence_t want, cadence_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch (%0s): power %0d/%0d cadence %0d/%0d updated %0b/%0b", what,
               want.power, got.power, want.cadence, got.cadence, want.updated, got.updated);
  endtask

  always @(posedge clk) begin : scoreboard
    reading_t r;
    cadence_t want;
    cadence_t got;
    if (!rst) begin
      if (in_if.valid && in_if.ready) begin
        r    = {in_if.flags, in_if.power_watts, in_if.crank_revs, in_if.crank_time};
        want = predict_cadence(r);
        if (row_fixed) begin
          want.cadence = row_cadence;
          want.updated = row_updated;
        end
        pending_cadence.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        got = {out_if.power_out, out_if.cadence_rpm, out_if.cadence_updated};
        if (pending_cadence.size() == 0) begin
          report_error("no item pending", '0, got);
        end else begin
          want = pending_cadence.pop_front();
          if (got.power !== want.power || got.cadence !== want.cadence ||
              got.updated !== want.updated)
            report_error("field", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : receiver
    int unsigned mode;
    int unsigned left;
    int unsigned hold_left;
    out_if.ready = 1'b0;
    mode = 0;
    left = 0;
    hold_left = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_if.ready = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 2);
          left = $urandom_range(10, 80);
        end
        left--;
        case (mode)
          0: begin
            out_if.ready = 1'b1;
          end
          1: begin
            out_if.ready = $urandom_range(0, 1);
          end
          default: begin
            out_if.ready = ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  task automatic send_reading(reading_t r, bit fixed, logic [15:0] cad, bit upd);
    @(negedge clk);
    in_if.valid       = 1'b1;
    in_if.flags       = r.flags;
    in_if.power_watts = r.power;
    in_if.crank_revs  = r.revs;
    in_if.crank_time  = r.evt;
    row_fixed   = fixed;
    row_cadence = cad;
    row_updated = upd;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic pause_sender(int unsigned n);
    @(negedge clk);
    in_if.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_empty();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_cadence.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(logic [7:0] flags, logic signed [15:0] power, logic [15:0] revs,
                         logic [15:0] evt, bit fixed, logic [15:0] cad, bit upd);
    row_t row;
    row.rd      = {flags, power, revs, evt};
    row.fixed   = fixed;
    row.cadence = cad;
    row.updated = upd;
    plan.push_back(row);
  endtask

  initial begin : stimulus
    reading_t    r;
    int unsigned pick;
    int unsigned burst;
    int unsigned miss_run;
    logic [15:0] walk_revs;
    logic [15:0] walk_evt;
    in_if.valid       = 1'b0;
    in_if.flags       = '0;
    in_if.power_watts = '0;
    in_if.crank_revs  = '0;
    in_if.crank_time  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    //      flags  power    revs      time      fix  cadence  upd
    add_row(8'h00, 32767,   16'hffff, 16'hffff, 1,   0,       0);
    add_row(8'h23, -32768,  16'h0000, 16'h0000, 1,   0,       0);
    add_row(8'h23, 100,     16'h0001, 16'd1024, 1,   60,      1);
    add_row(8'h23, 0,       16'h0002, 16'd1024, 1,   60,      0);
    add_row(8'h23, -1,      16'h0001, 16'h0000, 1,   60,      0);
    add_row(8'h23, 1,       16'h0001, 16'h0005, 1,   60,      0);
    add_row(8'h23, 250,     16'h0001, 16'h0005, 1,   0,       0);
    add_row(8'h23, -250,    16'hffff, 16'h0006, 1,   65535,   1);
    add_row(8'h23, 12345,   16'h0000, 16'hffff, 1,   65535,   0);
    add_row(8'h23, -12345,  16'hffff, 16'h0000, 1,   61440,   1);
    add_row(8'hff, 23130,   16'h1234, 16'h4321, 1,   61440,   0);
    add_row(8'h22, -23131,  16'h0000, 16'h0000, 1,   61440,   0);
    add_row(8'h24, 7,       16'hffff, 16'h0000, 1,   61440,   0);
    add_row(8'h23, 300,     16'h0000, 16'h0000, 1,   61440,   0);
    add_row(8'h23, 301,     16'h0001, 16'hffff, 1,   0,       1);
    add_row(8'h23, 302,     16'h0100, 16'hfff0, 1,   65535,   1);
    add_row(8'h23, 303,     16'h0105, 16'h1234, 0,   0,       0);
    add_row(8'h63, -300,    16'h0106, 16'h1634, 0,   0,       0);
    add_row(8'hdc, 16384,   16'haaaa, 16'h5555, 0,   0,       0);
    add_row(8'h23, -16385,  16'h0106, 16'h1634, 0,   0,       0);
    add_row(8'h23, 4660,    16'h0106, 16'h1a34, 0,   0,       0);
    add_row(8'h23, -4661,   16'h0109, 16'h0e34, 0,   0,       0);

    foreach (plan[i]) begin
      send_reading(plan[i].rd, plan[i].fixed, plan[i].cadence, plan[i].updated);
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 40));
    end
    wait_empty();
    row_fixed = 1'b0;

    walk_revs = $urandom;
    walk_evt  = $urandom;
    burst     = 0;
    miss_run  = 0;
    for (int n = 0; n < ITEMS; n++) begin
      if (n == 150) hold_req = 1'b1;
      if (n == 320) wait_empty();
      r.flags = ccad_pkg::FLAGS_MATCH;
      r.power = $urandom;
      if (miss_run != 0) begin
        miss_run--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
          walk_revs += $urandom_range(1, 3);
          walk_evt  += $urandom_range(300, 2500);
        end else if (pick < 66) begin
          miss_run = $urandom_range(1, 6);
        end else if (pick < 76) begin
          walk_revs += $urandom_range(1, 60);
          walk_evt  += $urandom_range(0, 3);
        end else if (pick < 86) begin
          walk_revs = $urandom;
          walk_evt  = $urandom;
        end else begin
          r.flags = $urandom;
        end
      end
      if (r.flags == ccad_pkg::FLAGS_MATCH) begin
        r.revs = walk_revs;
        r.evt  = walk_evt;
      end else begin
        r.revs = $urandom;
        r.evt  = $urandom;
      end
      send_reading(r, 1'b0, '0, 1'b0);
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 40));
      end else begin
        burst--;
      end
    end

    wait_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
